// ===== design/tsadd_pkg.sv =====
// Shared beat types and binary64 constants for the TwoSum unit.
package tsadd_pkg;

    localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] F64_SIGN = 64'h8000_0000_0000_0000;
    localparam logic [10:0] EXP_MAX  = 11'h7FF;

    typedef struct packed {
        logic [63:0] a_bits;
        logic [63:0] b_bits;
        logic        last_in;
    } req_beat_t;

    typedef struct packed {
        logic [63:0] sum_bits;
        logic [63:0] error_bits;
        logic        last_out;
    } rsp_beat_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] bb;
        logic [63:0] t;
        logic [63:0] u;
        logic        last;
    } side_t;

endpackage

// ===== design/fp64_two_sum_error_free_add_unit.sv =====
// Top level: TwoSum of two binary64 operands as a chain of six pipelined adders.
//
// Usage: the request channel (req_valid, req_stall, req) carries one beat
// per item with operands a_bits, b_bits and the vector-end flag last_in.
// The response channel (rsp_valid, rsp_stall, rsp) returns the rounded sum,
// its exact rounding error and last_out, one beat per request, in order.
// The work runs through six four-stage adders in series:
// s = a+b, bb = s-a, t1 = s-bb, t3 = b-bb, t2 = a-t1, err = t2+t3.
// Throughput is one beat per cycle while rsp_stall is low, set by the
// fully pipelined adder stages.
// Reset clears all stage valid bits; no beats are in flight after reset.
// When rsp_stall is high, the output holds; earlier stages keep filling
// any empty slots, so up to 24 beats are absorbed before req_stall rises.
module fp64_two_sum_error_free_add_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  tsadd_pkg::req_beat_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tsadd_pkg::rsp_beat_t rsp
);
    import tsadd_pkg::*;

    logic        vld [0:6];
    logic        rdy [0:6];
    side_t       sd_in  [0:5];
    side_t       sd_out [0:5];
    logic [63:0] opx [0:5];
    logic [63:0] opy [0:5];
    logic [63:0] res [0:5];

    assign vld[0]    = req_valid;
    assign req_stall = !rdy[0];
    assign rdy[6]    = !rsp_stall;
    assign rsp_valid = vld[6];

    always_comb
    begin
        sd_in[0]      = '0;
        sd_in[0].a    = req.a_bits;
        sd_in[0].b    = req.b_bits;
        sd_in[0].last = req.last_in;
        opx[0]        = req.a_bits;
        opy[0]        = req.b_bits;

        sd_in[1]      = sd_out[0];
        sd_in[1].s    = res[0];
        opx[1]        = res[0];
        opy[1]        = sd_out[0].a ^ F64_SIGN;

        sd_in[2]      = sd_out[1];
        sd_in[2].bb   = res[1];
        opx[2]        = sd_out[1].s;
        opy[2]        = res[1] ^ F64_SIGN;

        sd_in[3]      = sd_out[2];
        sd_in[3].t    = res[2];
        opx[3]        = sd_out[2].b;
        opy[3]        = sd_out[2].bb ^ F64_SIGN;

        sd_in[4]      = sd_out[3];
        sd_in[4].u    = res[3];
        opx[4]        = sd_out[3].a;
        opy[4]        = sd_out[3].t ^ F64_SIGN;

        sd_in[5]      = sd_out[4];
        opx[5]        = res[4];
        opy[5]        = sd_out[4].u;

        rsp.sum_bits   = sd_out[5].s;
        rsp.error_bits = res[5];
        rsp.last_out   = sd_out[5].last;
    end

    genvar k;
    generate
        for (k = 0; k < 6; k++)
        begin : g_add
            tsadd_fadd_pipe u_add (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (vld[k]),
                .up_ready (rdy[k]),
                .x        (opx[k]),
                .y        (opy[k]),
                .up_side  (sd_in[k]),
                .dn_valid (vld[k+1]),
                .dn_ready (rdy[k+1]),
                .result   (res[k]),
                .dn_side  (sd_out[k])
            );
        end
    endgenerate

endmodule

// ===== design/tsadd_fadd_pipe.sv =====
// Four-stage binary64 round-to-nearest-even adder with sideband and stall chain.
module tsadd_fadd_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [63:0]      x,
    input  logic [63:0]      y,
    input  tsadd_pkg::side_t up_side,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [63:0]      result,
    output tsadd_pkg::side_t dn_side
);
    import tsadd_pkg::*;

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sign;
        logic        same;
        logic [11:0] e;
        logic [52:0] ma;
        logic [52:0] mb;
        logic [10:0] d;
    } st1_t;

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sign;
        logic        same;
        logic [11:0] e;
        logic [63:0] m;
    } st2_t;

    typedef struct packed {
        logic        spec;
        logic [63:0] spec_val;
        logic        sign;
        logic        zero;
        logic [11:0] e;
        logic [62:0] m;
        logic [5:0]  sh;
    } st3_t;

    function automatic logic [5:0] lzc63(input logic [62:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i])
            begin
                n = 6'(62 - i);
            end
        end
        return n;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    logic [63:0] res_reg, res_next;
    side_t sd1_reg, sd2_reg, sd3_reg, sd4_reg;

    assign en4      = !v4_reg || dn_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;
    assign dn_valid = v4_reg;
    assign result   = res_reg;
    assign dn_side  = sd4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= up_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            st1_reg <= st1_next;
            sd1_reg <= up_side;
        end
        if (en2)
        begin
            st2_reg <= st2_next;
            sd2_reg <= sd1_reg;
        end
        if (en3)
        begin
            st3_reg <= st3_next;
            sd3_reg <= sd2_reg;
        end
        if (en4)
        begin
            res_reg <= res_next;
            sd4_reg <= sd3_reg;
        end
    end

    // stage 1: specials, magnitude swap, exponent difference
    always_comb
    begin
        logic        xm, ym, nx, ny;
        logic [63:0] hi, lo;
        logic [10:0] ea, eb;
        xm = x[62:52] == EXP_MAX;
        ym = y[62:52] == EXP_MAX;
        nx = xm && (x[51:0] != 52'd0);
        ny = ym && (y[51:0] != 52'd0);
        if (x[62:0] >= y[62:0])
        begin
            hi = x;
            lo = y;
        end
        else
        begin
            hi = y;
            lo = x;
        end
        ea = (hi[62:52] == 11'd0) ? 11'd1 : hi[62:52];
        eb = (lo[62:52] == 11'd0) ? 11'd1 : lo[62:52];
        st1_next.sign = hi[63];
        st1_next.same = hi[63] == lo[63];
        st1_next.e    = {1'b0, ea};
        st1_next.ma   = {hi[62:52] != 11'd0, hi[51:0]};
        st1_next.mb   = {lo[62:52] != 11'd0, lo[51:0]};
        st1_next.d    = ea - eb;
        st1_next.spec = 1'b1;
        if (nx || ny)
            st1_next.spec_val = F64_QNAN;
        else if (xm)
            st1_next.spec_val = (ym && (x[63] != y[63])) ? F64_QNAN : x;
        else if (ym)
            st1_next.spec_val = y;
        else
        begin
            st1_next.spec     = 1'b0;
            st1_next.spec_val = 64'd0;
        end
    end

    // stage 2: align with sticky, add or subtract
    always_comb
    begin
        logic [63:0] maw, mbw, mbs;
        maw = {1'b0, st1_reg.ma, 10'd0};
        mbw = {1'b0, st1_reg.mb, 10'd0};
        if (st1_reg.d >= 11'd64)
            mbs = {63'd0, |st1_reg.mb};
        else
            mbs = (mbw >> st1_reg.d[5:0])
                | {63'd0, (mbw & ((64'd1 << st1_reg.d[5:0]) - 64'd1)) != 64'd0};
        st2_next.spec     = st1_reg.spec;
        st2_next.spec_val = st1_reg.spec_val;
        st2_next.sign     = st1_reg.sign;
        st2_next.same     = st1_reg.same;
        st2_next.e        = st1_reg.e;
        st2_next.m        = st1_reg.same ? maw + mbs : maw - mbs;
    end

    // stage 3: carry fold or leading-zero count
    always_comb
    begin
        logic [62:0] mn;
        logic [11:0] en, em1;
        logic [5:0]  lz;
        if (st2_reg.same && st2_reg.m[63])
        begin
            mn = {st2_reg.m[63:2], st2_reg.m[1] | st2_reg.m[0]};
            en = st2_reg.e + 12'd1;
        end
        else
        begin
            mn = st2_reg.m[62:0];
            en = st2_reg.e;
        end
        lz  = lzc63(mn);
        em1 = en - 12'd1;
        st3_next.spec     = st2_reg.spec;
        st3_next.spec_val = st2_reg.spec_val;
        st3_next.sign     = st2_reg.sign;
        st3_next.zero     = !st2_reg.same && (st2_reg.m == 64'd0);
        st3_next.e        = en;
        st3_next.m        = mn;
        if (st2_reg.same)
            st3_next.sh = 6'd0;
        else if (em1 < {6'd0, lz})
            st3_next.sh = em1[5:0];
        else
            st3_next.sh = lz;
    end

    // stage 4: normalize, round, pack
    always_comb
    begin
        logic [62:0] mn;
        logic [11:0] en;
        logic [53:0] mr;
        logic        inc;
        mn  = st3_reg.m << st3_reg.sh;
        en  = st3_reg.e - {6'd0, st3_reg.sh};
        inc = (mn[9:0] > 10'h200) || ((mn[9:0] == 10'h200) && mn[10]);
        mr  = {1'b0, mn[62:10]} + {53'd0, inc};
        if (mr[53])
        begin
            mr = {1'b0, mr[53:1]};
            en = en + 12'd1;
        end
        if (st3_reg.spec)
            res_next = st3_reg.spec_val;
        else if (st3_reg.zero)
            res_next = 64'd0;
        else if (en >= {1'b0, EXP_MAX})
            res_next = {st3_reg.sign, EXP_MAX, 52'd0};
        else
            res_next = {st3_reg.sign, mr[52] ? en[10:0] : 11'd0, mr[51:0]};
    end

endmodule

// ===== dv/fp64_two_sum_error_free_add_unit_chk.sv =====
// Checker for the TwoSum unit: predicts sum, rounding error and last flag per beat and compares.
module fp64_two_sum_error_free_add_unit_chk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  tsadd_pkg::req_beat_t req,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  tsadd_pkg::rsp_beat_t rsp,
    output int                   fail_count,
    output int                   pending
);
    import tsadd_pkg::*;

    rsp_beat_t sums_due[$];

    function automatic logic f64_is_nan(logic [63:0] x);
        return x[62:52] == EXP_MAX && x[51:0] != 52'd0;
    endfunction

    function automatic logic [63:0] f64_add(logic [63:0] x, logic [63:0] y);
        logic [63:0] hi, lo, ma, mb, m, lost, field;
        logic [63:0] sgn;
        logic [9:0]  rem;
        int          ea, eb, e, d;
        if (f64_is_nan(x) || f64_is_nan(y))
            return F64_QNAN;
        if (x[62:52] == EXP_MAX)
        begin
            if (y[62:52] == EXP_MAX && x[63] != y[63])
                return F64_QNAN;
            return x;
        end
        if (y[62:52] == EXP_MAX)
            return y;
        if (x[62:0] >= y[62:0])
        begin
            hi = x;
            lo = y;
        end
        else
        begin
            hi = y;
            lo = x;
        end
        sgn = hi & F64_SIGN;
        ea = int'(hi[62:52]);
        eb = int'(lo[62:52]);
        ma = {12'd0, hi[51:0]};
        mb = {12'd0, lo[51:0]};
        if (ea == 0) ea = 1; else ma[52] = 1'b1;
        if (eb == 0) eb = 1; else mb[52] = 1'b1;
        ma = ma << 10;
        mb = mb << 10;
        d = ea - eb;
        if (d >= 64)
            mb = (mb != 0) ? 64'd1 : 64'd0;
        else if (d > 0)
        begin
            lost = mb & ((64'd1 << d) - 64'd1);
            mb = (mb >> d) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        e = ea;
        if (hi[63] == lo[63])
        begin
            m = ma + mb;
            if (m[63])
            begin
                m = (m >> 1) | {63'd0, m[0]};
                e++;
            end
        end
        else
        begin
            m = ma - mb;
            if (m == 0)
                return 64'd0;
            while (!m[62] && e > 1)
            begin
                m = m << 1;
                e--;
            end
        end
        rem = m[9:0];
        m = m >> 10;
        if (rem > 10'h200 || (rem == 10'h200 && m[0]))
            m++;
        if (m == (64'd1 << 53))
        begin
            m = m >> 1;
            e++;
        end
        if (e >= 2047)
            return sgn | {1'b0, EXP_MAX, 52'd0};
        field = m[52] ? 64'(e) : 64'd0;
        return sgn | (field << 52) | {12'd0, m[51:0]};
    endfunction

    function automatic logic [63:0] f64_sub(logic [63:0] x, logic [63:0] y);
        return f64_add(x, y ^ F64_SIGN);
    endfunction

    function automatic rsp_beat_t two_sum(req_beat_t r);
        rsp_beat_t o;
        logic [63:0] s, bb;
        s = f64_add(r.a_bits, r.b_bits);
        bb = f64_sub(s, r.a_bits);
        o.sum_bits = s;
        o.error_bits = f64_add(f64_sub(r.a_bits, f64_sub(s, bb)), f64_sub(r.b_bits, bb));
        o.last_out = r.last_in;
        return o;
    endfunction

    assign pending = sums_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        int        errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            sums_due.delete();
        end
        else
        begin
            errs = 0;
            if (req_valid && !req_stall)
                sums_due.push_back(two_sum(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $display("%0t unexpected beat: expected none, actual %h", $time, rsp);
                    errs++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (rsp.sum_bits !== want.sum_bits)
                    begin
                        $display("%0t sum: expected %h, actual %h", $time,
                                 want.sum_bits, rsp.sum_bits);
                        errs++;
                    end
                    if (rsp.error_bits !== want.error_bits)
                    begin
                        $display("%0t error: expected %h, actual %h", $time,
                                 want.error_bits, rsp.error_bits);
                        errs++;
                    end
                    if (rsp.last_out !== want.last_out)
                    begin
                        $display("%0t last: expected %b, actual %b", $time,
                                 want.last_out, rsp.last_out);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== dv/fp64_two_sum_error_free_add_unit_tb.sv =====
// Testbench top for the TwoSum unit: stimulus, idling, watchdog and verdict.
module fp64_two_sum_error_free_add_unit_tb;
    import tsadd_pkg::*;

    localparam int RANDOM_BEATS = 1700;
    localparam int WATCHDOG = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    logic      calm = 1'b0;
    logic      hold_off = 1'b0;
    logic [63:0] edge_vals [0:15];

    always #6 clk = ~clk;

    fp64_two_sum_error_free_add_unit dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    fp64_two_sum_error_free_add_unit_chk chk (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [63:0] pick_operand(logic [63:0] other);
        logic [63:0] v;
        int kind;
        kind = $urandom_range(0, 9);
        v = {$urandom, $urandom};
        case (kind)
            0: v = edge_vals[$urandom_range(0, 15)] ^ {1'($urandom_range(0, 1)), 63'd0};
            1: v[62:52] = 11'd0;
            2: v[62:52] = other[62:52] + 11'($urandom_range(0, 3)) - 11'd1;
            3: v = {~other[63], other[62:52], other[51:0] ^ 52'($urandom_range(0, 15))};
            4: v[62:52] = other[62:52] - 11'($urandom_range(50, 60));
            5: v = {~other[63], other[62:0]};
            default: v[62:52] = 11'($urandom_range(900, 1150));
        endcase
        return v;
    endfunction

    task automatic send(logic [63:0] a, logic [63:0] b);
        req_valid <= 1'b1;
        req <= '{a_bits: a, b_bits: b, last_in: ($urandom_range(0, 7) == 0)};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 7);
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // receiver side idling, plus one long hold-off to back up the pipe
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_stall <= 1'b1;
                for (n = 0; n < 80; n++)
                    @(posedge clk);
                rsp_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("[fp64_two_sum_error_free_add_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] a, b;
        int i, j;
        edge_vals[0] = 64'h0000_0000_0000_0000;
        edge_vals[1] = 64'h0000_0000_0000_0001;
        edge_vals[2] = 64'h000F_FFFF_FFFF_FFFF;
        edge_vals[3] = 64'h0010_0000_0000_0000;
        edge_vals[4] = 64'h7FEF_FFFF_FFFF_FFFF;
        edge_vals[5] = 64'h7FF0_0000_0000_0000;
        edge_vals[6] = 64'h7FF8_0000_0000_0000;
        edge_vals[7] = 64'h7FF0_0000_0000_0001;
        edge_vals[8] = 64'h7FFF_FFFF_FFFF_FFFF;
        edge_vals[9] = 64'h3FF0_0000_0000_0000;
        edge_vals[10] = 64'h3CA0_0000_0000_0000;
        edge_vals[11] = 64'h3FF0_0000_0000_0001;
        edge_vals[12] = 64'h4340_0000_0000_0000;
        edge_vals[13] = 64'h3C90_0000_0000_0001;
        edge_vals[14] = 64'h7FE0_0000_0000_0000;
        edge_vals[15] = 64'h3FFF_FFFF_FFFF_FFFF;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: special values, cancellation, signed zeros, overflow, ties
        send(64'h0, 64'h8000_0000_0000_0000);
        send(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
        send(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
        send(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send(64'hFFF4_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send(64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
        send(64'h7FEF_FFFF_FFFF_FFFF, 64'h7C90_0000_0000_0000);
        send(64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000);
        send(64'h3FF0_0000_0000_0001, 64'h3CA0_0000_0000_0000);
        send(64'h3FF0_0000_0000_0000, 64'h3C90_0000_0000_0001);
        send(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send(64'h0010_0000_0000_0000, 64'h8000_0000_0000_0001);
        send(64'h4340_0000_0000_0000, 64'hBFF0_0000_0000_0000);
        send(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
        send(64'hAAAA_AAAA_AAAA_AAAA, 64'h0);

        for (i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 300)
            begin
                hold_off = 1'b1;
                for (j = 0; j < 60; j++)
                    send({$urandom, $urandom}, {$urandom, $urandom});
            end
            if (i == RANDOM_BEATS - 200)
                calm = 1'b1;
            a = pick_operand({$urandom, $urandom});
            b = pick_operand(a);
            if ($urandom_range(0, 1))
                send(a, b);
            else
                send(b, a);
            gap();
        end
        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("[fp64_two_sum_error_free_add_unit] OK");
        else
            $display("[fp64_two_sum_error_free_add_unit] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
design/tsadd_pkg.sv
design/tsadd_fadd_pipe.sv
design/fp64_two_sum_error_free_add_unit.sv
dv/fp64_two_sum_error_free_add_unit_chk.sv
dv/fp64_two_sum_error_free_add_unit_tb.sv
